FILE: rtl/core/ctr_pkg.sv
// Shared widths, reset constants, limit words and types for the compact target retarget block.
// No dependencies; used by ctr_cfg, ctr_divider, compact_target_retarget and the testbench.
package ctr_pkg;

   localparam int TARGET_WIDTH    = 256;
   localparam int BASE_LIMIT_BITS = TARGET_WIDTH - 20;
   localparam int V2_LIMIT_BITS   = TARGET_WIDTH - 48;
   localparam int HUGE_BITS       = TARGET_WIDTH + 21;

   localparam int SP_W    = 16;
   localparam int TS_W    = 20;
   localparam int TEN_W   = 20;
   localparam int DEN_W   = 21;
   localparam int A_W     = 22;
   localparam int ACT_W   = 33;
   localparam int NUM_W   = 35;
   localparam int MAG_W   = 34;
   localparam int MANT_W  = 23;
   localparam int PROD_W  = MANT_W + MAG_W;
   // fixed-point fraction bits: keeps at least 24 quotient bits for any nonzero product
   localparam int FRAC_BITS  = 44;
   localparam int QW         = PROD_W + FRAC_BITS + 1;
   localparam int DIV_STAGES = QW / 2;
   localparam int BQ_W       = $clog2(QW + 1);
   localparam int QI_W       = $clog2(QW);
   localparam int S_W        = $clog2(HUGE_BITS);
   localparam int L_W        = S_W + 2;
   localparam int NBY_W      = 6;

   localparam int RST_SPACING  = 60;
   localparam int RST_TIMESPAN = 120 * 60;
   localparam int RST_INTERVAL = RST_TIMESPAN / RST_SPACING;
   localparam int RST_NUM_BASE = (RST_INTERVAL - 1) * RST_SPACING;
   localparam int RST_DEN      = (RST_INTERVAL + 1) * RST_SPACING;
   localparam int RST_TEN_SP   = RST_SPACING * 10;

   typedef enum logic {
      REG_SPACING  = 1'b0,
      REG_TIMESPAN = 1'b1
   } ctr_reg_type;

   // compact encoding of an all-ones value of the given bit length
   function automatic logic [31:0] limit_word(input int bits);
      int          nb;
      int          avail;
      logic [23:0] w;
      nb = (bits + 7) / 8;
      if (nb <= 3) begin
         w = 24'((64'd1 << bits) - 64'd1);
         w = w << (8 * (3 - nb));
      end else begin
         avail = bits - 8 * (nb - 3);
         w = (avail >= 24) ? 24'hffffff : 24'((64'd1 << avail) - 64'd1);
      end
      if (w[23]) begin
         w  = w >> 8;
         nb = nb + 1;
      end
      return {8'(nb), w};
   endfunction

   localparam logic [31:0] LIMIT_BASE_WORD = limit_word(BASE_LIMIT_BITS);
   localparam logic [31:0] LIMIT_V2_WORD   = limit_word(V2_LIMIT_BITS);

   typedef struct packed {
      logic                    busy;
      logic [SP_W-1:0]         spacing;
      logic [TEN_W-1:0]        ten_spacing;
      logic signed [A_W-1:0]   num_base;
      logic [DEN_W-1:0]        den;
   } ctr_cfg_type;

   typedef struct packed {
      logic           go;
      logic           lim_v2;
      logic [S_W-1:0] shift;
   } ctr_side_type;

endpackage

FILE: rtl/core/ctr_cfg.sv
// Configuration registers and the derived retarget constants (interval, numerator base, divisor).
// Depends on ctr_pkg.
module ctr_cfg import ctr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output ctr_cfg_type cfg
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_START  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_MULT   = 4'b1000
   } ctr_state_type;

   ctr_state_type         state_ff, state_in;
   logic [SP_W-1:0]       spacing_ff;
   logic [TS_W-1:0]       timespan_ff;
   logic [SP_W-1:0]       sp_eff_ff;
   logic [SP_W-1:0]       rem_ff, rem_in;
   logic [TS_W-1:0]       quo_ff, quo_in;
   logic [4:0]            cnt_ff;
   logic signed [A_W-1:0] num_base_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [TEN_W-1:0]      ten_ff;
   logic                  wr;
   logic [SP_W:0]         r2;
   logic signed [A_W-1:0] im1;
   logic [DEN_W-1:0]      ip1;
   ctr_reg_type           idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = ctr_reg_type'(paddr[2]);
   assign prdata = (idx == REG_TIMESPAN) ? 32'(timespan_ff) : 32'(spacing_ff);

   // one restoring step of timespan / spacing per cycle
   always_comb begin
      r2 = {rem_ff, quo_ff[TS_W-1]};
      if (r2 >= {1'b0, sp_eff_ff}) begin
         rem_in = SP_W'(r2 - {1'b0, sp_eff_ff});
         quo_in = {quo_ff[TS_W-2:0], 1'b1};
      end else begin
         rem_in = r2[SP_W-1:0];
         quo_in = {quo_ff[TS_W-2:0], 1'b0};
      end
      im1 = $signed(A_W'(quo_ff)) - $signed(A_W'(1));
      ip1 = DEN_W'(quo_ff) + DEN_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   state_in = ST_IDLE;
         ST_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: if (cnt_ff == 5'd1) state_in = ST_MULT;
         ST_MULT:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      if (wr) state_in = ST_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         spacing_ff  <= SP_W'(RST_SPACING);
         timespan_ff <= TS_W'(RST_TIMESPAN);
         sp_eff_ff   <= SP_W'(RST_SPACING);
         num_base_ff <= A_W'(RST_NUM_BASE);
         den_ff      <= DEN_W'(RST_DEN);
         ten_ff      <= TEN_W'(RST_TEN_SP);
      end else begin
         state_ff <= state_in;
         if (wr) begin
            if (idx == REG_SPACING) spacing_ff <= pwdata[SP_W-1:0];
            else timespan_ff <= pwdata[TS_W-1:0];
         end
         if (state_ff == ST_START) begin
            sp_eff_ff <= (spacing_ff == '0) ? SP_W'(1) : spacing_ff;
         end
         if (state_ff == ST_MULT) begin
            num_base_ff <= A_W'(im1 * $signed({1'b0, sp_eff_ff}));
            den_ff      <= DEN_W'(ip1 * sp_eff_ff);
            ten_ff      <= TEN_W'(sp_eff_ff * 4'd10);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_START) begin
         rem_ff <= '0;
         quo_ff <= timespan_ff;
         cnt_ff <= 5'(TS_W);
      end else if (state_ff == ST_DIVIDE) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   assign cfg.busy        = (state_ff != ST_IDLE);
   assign cfg.spacing     = sp_eff_ff;
   assign cfg.ten_spacing = ten_ff;
   assign cfg.num_base    = num_base_ff;
   assign cfg.den         = den_ff;

endmodule

FILE: rtl/core/ctr_divider.sv
// Pipelined restoring divider: two quotient bits per stage. The divisor must be held
// constant while busy by the user; the block itself does not enforce it. Depends on ctr_pkg.
module ctr_divider import ctr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [QW-1:0]    in_dividend,
   input  ctr_side_type     in_side,
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [QW-1:0]    out_quotient,
   output ctr_side_type     out_side
);

   logic             valid_ff [DIV_STAGES];
   logic [QW-1:0]    work_ff  [DIV_STAGES];
   logic [DEN_W-1:0] rem_ff   [DIV_STAGES];
   ctr_side_type     side_ff  [DIV_STAGES];
   logic [QW-1:0]    work_in  [DIV_STAGES];
   logic [DEN_W-1:0] rem_in   [DIV_STAGES];
   logic             stg_ready[DIV_STAGES];
   logic             valid_src[DIV_STAGES];
   logic [QW-1:0]    work_src [DIV_STAGES];
   logic [DEN_W-1:0] rem_src  [DIV_STAGES];
   ctr_side_type     side_src [DIV_STAGES];

   function automatic logic [DEN_W+QW-1:0] div_step(input logic [DEN_W-1:0] r,
                                                    input logic [QW-1:0] w,
                                                    input logic [DEN_W-1:0] d);
      logic [DEN_W:0]   r2;
      logic [DEN_W-1:0] rn;
      logic             qb;
      r2 = {r, w[QW-1]};
      if (r2 >= {1'b0, d}) begin
         rn = DEN_W'(r2 - {1'b0, d});
         qb = 1'b1;
      end else begin
         rn = r2[DEN_W-1:0];
         qb = 1'b0;
      end
      return {rn, w[QW-2:0], qb};
   endfunction

   // what each stage takes in: the divider input for stage 0, else the stage before
   always_comb begin
      valid_src[0] = in_valid;
      work_src[0]  = in_dividend;
      rem_src[0]   = '0;
      side_src[0]  = in_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
         valid_src[k] = valid_ff[k-1];
         work_src[k]  = work_ff[k-1];
         rem_src[k]   = rem_ff[k-1];
         side_src[k]  = side_ff[k-1];
      end
   end

   always_comb begin
      logic [DEN_W+QW-1:0] t1;
      logic [DEN_W+QW-1:0] t2;
      for (int k = 0; k < DIV_STAGES; k++) begin
         t1 = div_step(rem_src[k], work_src[k], den);
         t2 = div_step(t1[DEN_W+QW-1:QW], t1[QW-1:0], den);
         rem_in[k]  = t2[DEN_W+QW-1:QW];
         work_in[k] = t2[QW-1:0];
      end
   end

   // stage k takes new data when empty or when its successor takes its item
   always_comb begin
      stg_ready[DIV_STAGES-1] = !valid_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         stg_ready[k] = !valid_ff[k] || stg_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) valid_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            if (stg_ready[k]) valid_ff[k] <= valid_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (stg_ready[k]) begin
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign in_ready     = stg_ready[0];
   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_quotient = work_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

FILE: rtl/core/compact_target_retarget.sv
// Top level of the compact target retarget block: request decode, multiply, divide, re-encode.
// Depends on ctr_pkg, ctr_cfg and ctr_divider.
//
// Usage:
//  - Request channel (req_*): one retarget item per accepted valid/stall handshake.
//  - Result channel (rsp_*): exactly one item per request, in request order.
//  - Register port: APB style, spacing at 0x0, timespan at 0x4; write only while idle.
//  - Throughput: one item per cycle while rsp_stall is low and no rebuild is running.
//  - Pipeline: 4 front stages, 51 divider stages at two quotient bits each,
//    3 encode stages and an output register ahead of rsp_valid; the first
//    front stage loads on the accepting edge.
//  - After a register write, the derived interval/divisor are rebuilt by a
//    one-bit-per-cycle divider: req_stall stays high until the rebuild is done.
//  - Reset: synchronous; all pipeline valids clear, registers return to
//    spacing 60 / timespan 7200 with derived constants ready at once.
//  - Receiver stall: each stage holds while full and blocked; empty stages
//    still fill, so requests keep flowing until the pipeline is full.
module compact_target_retarget import ctr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_prev_bits,
   input  logic [31:0] req_prev_time,
   input  logic [31:0] req_prev_prev_time,
   input  logic        req_proof_of_stake,
   input  logic        req_early_chain,
   input  logic        req_stake_limit_v2,
   input  logic        req_spacing_fix,
   input  logic        req_spacing_cap,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_bits,
   output logic        rsp_limited,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctr_cfg_type cfg;

   ctr_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---- handshake chain ----
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, rsp_valid_ff;
   logic f1_ready, f2_ready, f3_ready, f4_ready;
   logic b1_ready, b2_ready, b3_ready, out_ready;
   logic div_in_ready, div_out_valid;
   logic req_take;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign b3_ready  = !b3_valid_ff || out_ready;
   assign b2_ready  = !b2_valid_ff || b3_ready;
   assign b1_ready  = !b1_valid_ff || b2_ready;
   assign f4_ready  = !f4_valid_ff || div_in_ready;
   assign f3_ready  = !f3_valid_ff || f4_ready;
   assign f2_ready  = !f2_valid_ff || f3_ready;
   assign f1_ready  = !f1_valid_ff || f2_ready;

   // no new requests while derived constants are being rebuilt
   assign req_stall = !f1_ready || cfg.busy;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         f4_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (f1_ready)  f1_valid_ff  <= req_take;
         if (f2_ready)  f2_valid_ff  <= f1_valid_ff;
         if (f3_ready)  f3_valid_ff  <= f2_valid_ff;
         if (f4_ready)  f4_valid_ff  <= f3_valid_ff;
         if (b1_ready)  b1_valid_ff  <= div_out_valid;
         if (b2_ready)  b2_valid_ff  <= b1_valid_ff;
         if (b3_ready)  b3_valid_ff  <= b2_valid_ff;
         if (out_ready) rsp_valid_ff <= b3_valid_ff;
      end
   end

   // ---- F1: decode compact word, measure and clamp the spacing ----
   logic [7:0]              size_in;
   logic [MANT_W-1:0]       mant_in;
   logic signed [ACT_W-1:0] act_in;
   logic [7:0]              f1_size_ff;
   logic [MANT_W-1:0]       f1_mant_ff;
   logic                    f1_neg_ff, f1_early_ff, f1_lim_v2_ff;
   logic signed [ACT_W-1:0] f1_act_ff;

   always_comb begin
      size_in = req_prev_bits[31:24];
      mant_in = req_prev_bits[MANT_W-1:0];
      if (size_in == 8'd0)      mant_in = '0;
      else if (size_in == 8'd1) mant_in = mant_in >> 16;
      else if (size_in == 8'd2) mant_in = mant_in >> 8;
      act_in = $signed({1'b0, req_prev_time}) - $signed({1'b0, req_prev_prev_time});
      if (req_spacing_fix && act_in < 0) act_in = $signed(ACT_W'(cfg.spacing));
      if (req_spacing_cap && act_in > $signed(ACT_W'(cfg.ten_spacing)))
         act_in = $signed(ACT_W'(cfg.ten_spacing));
   end

   always_ff @(posedge clock) begin
      if (f1_ready) begin
         f1_size_ff   <= size_in;
         f1_mant_ff   <= mant_in;
         f1_neg_ff    <= req_prev_bits[23] && (size_in != 8'd0);
         f1_early_ff  <= req_early_chain;
         f1_lim_v2_ff <= req_proof_of_stake && req_stake_limit_v2;
         f1_act_ff    <= act_in;
      end
   end

   // ---- F2: numerator, oversize check ----
   function automatic logic [4:0] mant_bitlen(input logic [MANT_W-1:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < MANT_W; i++) if (v[i]) n = 5'(i + 1);
      return n;
   endfunction

   logic signed [NUM_W-1:0] num_in;
   logic [10:0]             shift_raw;
   logic                    huge_in;
   logic signed [NUM_W-1:0] f2_num_ff;
   logic [MANT_W-1:0]       f2_mant_ff;
   logic                    f2_neg_ff, f2_early_ff, f2_lim_v2_ff, f2_huge_ff;
   logic [S_W-1:0]          f2_shift_ff;

   always_comb begin
      num_in = $signed({{(NUM_W-A_W){cfg.num_base[A_W-1]}}, cfg.num_base})
             + $signed({{(NUM_W-ACT_W-1){f1_act_ff[ACT_W-1]}}, f1_act_ff, 1'b0});
      shift_raw = (f1_size_ff >= 8'd3) ? {f1_size_ff - 8'd3, 3'b000} : 11'd0;
      huge_in   = (12'(mant_bitlen(f1_mant_ff)) + 12'(shift_raw)) > 12'(HUGE_BITS);
   end

   always_ff @(posedge clock) begin
      if (f2_ready) begin
         f2_num_ff    <= num_in;
         f2_mant_ff   <= f1_mant_ff;
         f2_neg_ff    <= f1_neg_ff;
         f2_early_ff  <= f1_early_ff;
         f2_lim_v2_ff <= f1_lim_v2_ff;
         f2_huge_ff   <= huge_in;
         f2_shift_ff  <= shift_raw[S_W-1:0];
      end
   end

   // ---- F3: magnitude and go/no-go ----
   logic [NUM_W-1:0]  mag_full;
   logic              go_in;
   logic [MAG_W-1:0]  f3_mag_ff;
   logic [MANT_W-1:0] f3_mant_ff;
   ctr_side_type      f3_side_ff;

   always_comb begin
      mag_full = f2_num_ff[NUM_W-1] ? NUM_W'(-f2_num_ff) : NUM_W'(f2_num_ff);
      // sign of the target must match the sign of the numerator
      go_in = !f2_early_ff && (f2_mant_ff != '0) && (f2_num_ff != '0)
            && (f2_neg_ff == f2_num_ff[NUM_W-1]) && !f2_huge_ff;
   end

   always_ff @(posedge clock) begin
      if (f3_ready) begin
         f3_mag_ff         <= mag_full[MAG_W-1:0];
         f3_mant_ff        <= f2_mant_ff;
         f3_side_ff.go     <= go_in;
         f3_side_ff.lim_v2 <= f2_lim_v2_ff;
         f3_side_ff.shift  <= f2_shift_ff;
      end
   end

   // ---- F4: mantissa times numerator magnitude ----
   logic [QW-1:0] f4_dividend_ff;
   ctr_side_type  f4_side_ff;

   always_ff @(posedge clock) begin
      if (f4_ready) begin
         f4_dividend_ff <= QW'({PROD_W'(f3_mant_ff * f3_mag_ff), {FRAC_BITS{1'b0}}});
         f4_side_ff     <= f3_side_ff;
      end
   end

   // ---- divide by (interval+1)*spacing ----
   logic [QW-1:0] div_q;
   ctr_side_type  div_side;

   ctr_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (f4_valid_ff),
      .in_ready     (div_in_ready),
      .in_dividend  (f4_dividend_ff),
      .in_side      (f4_side_ff),
      .den          (cfg.den),
      .out_valid    (div_out_valid),
      .out_ready    (b1_ready),
      .out_quotient (div_q),
      .out_side     (div_side)
   );

   // ---- B1: quotient bit length ----
   function automatic logic [BQ_W-1:0] q_bitlen(input logic [QW-1:0] v);
      logic [BQ_W-1:0] n;
      n = '0;
      for (int i = 0; i < QW; i++) if (v[i]) n = BQ_W'(i + 1);
      return n;
   endfunction

   logic [QW-1:0]   b1_q_ff;
   logic [BQ_W-1:0] b1_bq_ff;
   ctr_side_type    b1_side_ff;

   always_ff @(posedge clock) begin
      if (b1_ready) begin
         b1_q_ff    <= div_q;
         b1_bq_ff   <= q_bitlen(div_q);
         b1_side_ff <= div_side;
      end
   end

   // ---- B2: true bit length, limit check, byte count, window position ----
   // q holds the quotient scaled by 2^FRAC_BITS over the target shift, so
   // the real length is bq + shift - FRAC_BITS.
   logic signed [L_W-1:0] len_in, lim_in, nb_full, base_in, bidx_full;
   logic [NBY_W-1:0]      nb_in;
   logic                  ok_in;
   logic [QW-1:0]         b2_q_ff;
   logic                  b2_ok_ff, b2_lim_v2_ff;
   logic [NBY_W-1:0]      b2_nb_ff;
   logic [QI_W-1:0]       b2_bidx_ff;
   logic [1:0]            b2_lsh_ff;

   always_comb begin
      len_in = $signed(L_W'(b1_bq_ff)) + $signed(L_W'(b1_side_ff.shift))
             - $signed(L_W'(FRAC_BITS));
      lim_in = b1_side_ff.lim_v2 ? $signed(L_W'(V2_LIMIT_BITS))
                                 : $signed(L_W'(BASE_LIMIT_BITS));
      ok_in   = b1_side_ff.go && (len_in > 0) && (len_in <= lim_in);
      nb_full = (len_in + $signed(L_W'(7))) >>> 3;
      nb_in   = nb_full[NBY_W-1:0];
      base_in = (nb_full > $signed(L_W'(3))) ? (nb_full - $signed(L_W'(3))) <<< 3
                                             : $signed(L_W'(0));
      bidx_full = base_in + $signed(L_W'(FRAC_BITS)) - $signed(L_W'(b1_side_ff.shift));
   end

   always_ff @(posedge clock) begin
      if (b2_ready) begin
         b2_q_ff      <= b1_q_ff;
         b2_ok_ff     <= ok_in;
         b2_lim_v2_ff <= b1_side_ff.lim_v2;
         b2_nb_ff     <= nb_in;
         b2_bidx_ff   <= bidx_full[QI_W-1:0];
         b2_lsh_ff    <= (nb_in <= NBY_W'(3)) ? 2'(NBY_W'(3) - nb_in) : 2'd0;
      end
   end

   // ---- B3: pick the 24-bit mantissa window ----
   logic [23:0]      win_in;
   logic             b3_ok_ff, b3_lim_v2_ff;
   logic [NBY_W-1:0] b3_nb_ff;
   logic [23:0]      b3_word_ff;

   assign win_in = 24'(b2_q_ff >> b2_bidx_ff);

   always_ff @(posedge clock) begin
      if (b3_ready) begin
         b3_ok_ff     <= b2_ok_ff;
         b3_lim_v2_ff <= b2_lim_v2_ff;
         b3_nb_ff     <= b2_nb_ff;
         b3_word_ff   <= win_in << {b2_lsh_ff, 3'b000};
      end
   end

   // ---- output register: sign-bit fix and limit substitution ----
   logic [23:0]      word_fix;
   logic [NBY_W-1:0] nb_fix;
   logic [31:0]      bits_in;
   logic [31:0]      rsp_bits_ff;
   logic             rsp_limited_ff;

   always_comb begin
      word_fix = b3_word_ff;
      nb_fix   = b3_nb_ff;
      // mantissa top bit would read as a sign: move up one byte
      if (b3_word_ff[23]) begin
         word_fix = b3_word_ff >> 8;
         nb_fix   = b3_nb_ff + NBY_W'(1);
      end
      if (b3_ok_ff)          bits_in = {8'(nb_fix), word_fix};
      else if (b3_lim_v2_ff) bits_in = LIMIT_V2_WORD;
      else                   bits_in = LIMIT_BASE_WORD;
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_bits_ff    <= bits_in;
         rsp_limited_ff <= !b3_ok_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_bits = rsp_bits_ff;
   assign rsp_limited   = rsp_limited_ff;

endmodule

FILE: verif/compact_target_retarget_tb.sv
// Self-checking testbench for compact_target_retarget: retarget items are predicted
// bit-exact and compared in order. Depends on ctr_pkg and the compact_target_retarget RTL.
`timescale 1ns / 1ps

module compact_target_retarget_tb import ctr_pkg::*; ();

   // one retarget item as driven on the req_ channel
   typedef struct {
      logic [31:0] prev_bits;
      logic [31:0] prev_time;
      logic [31:0] prev_prev_time;
      logic        pos;
      logic        early;
      logic        v2;
      logic        fix;
      logic        cap;
   } retarget_req_type;

   // one result item
   typedef struct {
      logic [31:0] next_bits;
      logic        limited;
   } retarget_rsp_type;

   localparam int WIDE       = 384;
   localparam int LIMIT_CYC  = 400000;
   localparam int DRAIN_CYC  = 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_prev_bits;
   logic [31:0] req_prev_time;
   logic [31:0] req_prev_prev_time;
   logic        req_proof_of_stake;
   logic        req_early_chain;
   logic        req_stake_limit_v2;
   logic        req_spacing_fix;
   logic        req_spacing_cap;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_next_bits;
   logic        rsp_limited;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   compact_target_retarget dut (.*);

   // Shadow copy of the two registers.
   logic [15:0]     spacing_q  = 16'd60;
   logic [19:0]     timespan_q = 20'd7200;

   retarget_req_type pending_reqs[$];
   retarget_rsp_type expected_rsps[$];
   int              errors     = 0;
   int              n_sent     = 0;
   int              n_checked  = 0;
   int              n_limited  = 0;
   int              cycles     = 0;
   int              req_gap_max = 10;
   int              rsp_gap_max = 10;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int bit_len(logic [WIDE-1:0] x);
      int n;
      n = 0;
      for (int i = 0; i < WIDE; i++)
         if (x[i]) n = i + 1;
      return n;
   endfunction

   // compact word of a nonnegative wide value
   function automatic logic [31:0] compact_of(logic [WIDE-1:0] x);
      int              nbytes;
      logic [23:0]     word;
      logic [WIDE-1:0] sh;
      nbytes = (bit_len(x) + 7) / 8;
      if (nbytes <= 3) begin
         word = x[23:0];
         word = word << (8 * (3 - nbytes));
      end else begin
         sh   = x >> (8 * (nbytes - 3));
         word = sh[23:0];
      end
      // mantissa top bit would read as sign: grow exponent instead
      if (word[23]) begin
         word   = word >> 8;
         nbytes = nbytes + 1;
      end
      return {nbytes[7:0], word};
   endfunction

   function automatic retarget_rsp_type predict_retarget(retarget_req_type r);
      retarget_rsp_type res;
      longint          sp, interval, actual, num, den, mag;
      int              size, mbits, shift, lbits, bl;
      logic [22:0]     mant;
      logic            neg;
      logic            ok;
      logic [WIDE-1:0] x;
      lbits    = (r.pos && r.v2) ? V2_LIMIT_BITS : BASE_LIMIT_BITS;
      sp       = (spacing_q == 0) ? 1 : longint'(spacing_q);   // zero spacing reads as one
      interval = longint'(timespan_q) / sp;
      actual   = longint'({32'd0, r.prev_time}) - longint'({32'd0, r.prev_prev_time});
      if (r.fix && actual < 0) actual = sp;
      if (r.cap && actual > sp * 10) actual = sp * 10;
      num  = (interval - 1) * sp + 2 * actual;
      den  = (interval + 1) * sp;
      size = int'(r.prev_bits[31:24]);
      mant = r.prev_bits[22:0];
      neg  = r.prev_bits[23] && size >= 1;
      if (size < 3) mant = mant >> (8 * (3 - size));
      ok = 1'b0;
      if (!r.early && mant != 0 && num != 0 && neg == (num < 0)) begin
         mbits = 0;
         for (int i = 0; i < 23; i++)
            if (mant[i]) mbits = i + 1;
         shift = (size >= 3) ? 8 * (size - 3) : 0;
         // anything this large saturates without arithmetic
         if (mbits + shift <= TARGET_WIDTH + 21) begin
            mag = (num < 0) ? -num : num;
            x   = WIDE'(mant) << shift;
            x   = x * WIDE'(mag);
            x   = x / WIDE'(den);
            bl  = bit_len(x);
            ok  = bl != 0 && bl <= lbits;
         end
      end
      if (ok) begin
         res.next_bits = compact_of(x);
         res.limited   = 1'b0;
      end else begin
         x             = (WIDE'(1) << lbits) - WIDE'(1);
         res.next_bits = compact_of(x);
         res.limited   = 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------ checks
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("ERROR @%0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   // ------------------------------------------------------------------ driver
   int req_gap = 0;
   always @(posedge clock) begin
      retarget_req_type cur;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            cur.prev_bits      = req_prev_bits;
            cur.prev_time      = req_prev_time;
            cur.prev_prev_time = req_prev_prev_time;
            cur.pos            = req_proof_of_stake;
            cur.early          = req_early_chain;
            cur.v2             = req_stake_limit_v2;
            cur.fix            = req_spacing_fix;
            cur.cap            = req_spacing_cap;
            expected_rsps.push_back(predict_retarget(cur));
            n_sent++;
         end
         // channel free: either idle out a gap or present the next item
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur = pending_reqs.pop_front();
               req_prev_bits      <= cur.prev_bits;
               req_prev_time      <= cur.prev_time;
               req_prev_prev_time <= cur.prev_prev_time;
               req_proof_of_stake <= cur.pos;
               req_early_chain    <= cur.early;
               req_stake_limit_v2 <= cur.v2;
               req_spacing_fix    <= cur.fix;
               req_spacing_cap    <= cur.cap;
               req_valid          <= 1'b1;
               req_gap = $urandom_range(0, req_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------------- monitor
   int rsp_hold = 0;
   always @(posedge clock) begin
      retarget_rsp_type want;
      cycles++;
      if (cycles > LIMIT_CYC) begin
         $display("timeout after %0d cycles, %0d items outstanding",
                  cycles, expected_rsps.size());
         $display("*** FAILED ***");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected item, next_bits", rsp_next_bits, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_next_bits !== want.next_bits)
                  report("next_bits", rsp_next_bits, want.next_bits);
               if (rsp_limited !== want.limited)
                  report("limited", 32'(rsp_limited), 32'(want.limited));
               n_checked++;
               if (want.limited) n_limited++;
            end
            rsp_hold = $urandom_range(0, rsp_gap_max);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic csr_write(input ctr_reg_type idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_SPACING) spacing_q = value[15:0];
      else                    timespan_q = value[19:0];
   endtask

   task automatic add_item(input logic [31:0] b, input logic [31:0] t1, input logic [31:0] t0,
                           input logic [4:0] flags);
      retarget_req_type r;
      r.prev_bits = b;  r.prev_time = t1;  r.prev_prev_time = t0;
      {r.pos, r.early, r.v2, r.fix, r.cap} = flags;
      pending_reqs.push_back(r);
   endtask

   task automatic add_directed();
      add_item(32'h1d00ffff, 32'd1060,     32'd1000,     5'b00000);  // on-target spacing
      add_item(32'h00000000, 32'd0,        32'd0,        5'b00000);  // all zero
      add_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 5'b11111);  // all ones, early chain
      add_item(32'h1e0fffff, 32'd500,      32'd100,      5'b01000);  // early chain only
      add_item(32'h00800000, 32'd10,       32'd0,        5'b00000);  // negative zero
      add_item(32'h01003456, 32'd10,       32'd0,        5'b00000);  // exponent one
      add_item(32'h02123456, 32'd10,       32'd0,        5'b00000);  // exponent two
      add_item(32'h03123456, 32'd10,       32'd0,        5'b00000);
      add_item(32'hff7fffff, 32'd10,       32'd0,        5'b00000);  // huge exponent
      add_item(32'h25400000, 32'd70,       32'd10,       5'b00000);  // just above width
      add_item(32'h1b0404cb, 32'd0,        32'hffffffff, 5'b00000);  // large negative spacing
      add_item(32'h1b0404cb, 32'd0,        32'hffffffff, 5'b00010);  // same, fixed
      add_item(32'h1b8404cb, 32'd0,        32'hffffffff, 5'b00000);  // negative target
      add_item(32'h1b0404cb, 32'hffffffff, 32'd0,       5'b00000);  // large spacing
      add_item(32'h1b0404cb, 32'hffffffff, 32'd0,       5'b00001);  // same, capped
      add_item(32'h1c00ffff, 32'd3000,     32'd1000,     5'b10100);  // stake, v2 limit
      add_item(32'h1c00ffff, 32'd3000,     32'd1000,     5'b10000);  // stake, base limit
      add_item(32'h1f0fffff, 32'd100,      32'd100,      5'b00100);  // v2 flag without stake
      add_item(32'h1b7fffff, 32'd1,        32'd0,        5'b00011);
      add_item(32'h04000001, 32'd200,      32'd100,      5'b00000);
   endtask

   function automatic logic [31:0] rand_bits();
      logic [31:0] b;
      b = $urandom();
      if ($urandom_range(0, 4) != 0) begin
         // mostly realistic: exponent small enough to pass the oversize check
         b[31:24] = 8'($urandom_range(0, 34));
         b[23]    = ($urandom_range(0, 15) == 0);
      end
      return b;
   endfunction

   task automatic add_random(input int n);
      logic [31:0] t0, t1;
      int          span;
      for (int i = 0; i < n; i++) begin
         t0 = $urandom();
         if ($urandom_range(0, 5) == 0) begin
            t1 = $urandom();                           // noise
         end else begin
            span = (spacing_q == 0) ? 1 : int'(spacing_q);
            t1 = t0 + 32'($urandom_range(0, 24 * span)) - 32'($urandom_range(0, 2 * span));
         end
         add_item(rand_bits(), t1, t0,
                  {1'($urandom), ($urandom_range(0, 15) == 0), 3'($urandom)});
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   initial begin
      logic [15:0] sp_set[6] = '{16'd60, 16'd1, 16'd65535, 16'd0, 16'd600, 16'd0};
      logic [19:0] ts_set[6] = '{20'd7200, 20'd1, 20'd1048575, 20'd0, 20'd3600, 20'd0};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      req_prev_bits <= '0;  req_prev_time <= '0;  req_prev_prev_time <= '0;
      req_proof_of_stake <= 1'b0;  req_early_chain <= 1'b0;  req_stake_limit_v2 <= 1'b0;
      req_spacing_fix <= 1'b0;  req_spacing_cap <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0 runs on reset values; later phases rewrite both registers
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            sp_set[5] = 16'($urandom_range(1, 65535));
            ts_set[5] = 20'($urandom_range(1, 1048575));
            csr_write(REG_SPACING, 32'(sp_set[ph]));
            csr_write(REG_TIMESPAN, 32'(ts_set[ph]));
         end
         // alternate stretches with heavy idling and with none
         req_gap_max = (ph % 2 == 0) ? 10 : 0;
         rsp_gap_max = (ph % 3 == 1) ? 0 : 10;
         @(negedge clock);
         add_directed();
         add_random(250);
         drain();
      end

      while (expected_rsps.size() > 0) begin
         report("missing item, next_bits", 32'd0, expected_rsps[0].next_bits);
         void'(expected_rsps.pop_front());
      end
      $display("Ran %0d retarget items over 6 register settings, %0d checked, %0d saturated.",
               n_sent, n_checked, n_limited);
      $display("Mismatches: %0d", errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: compact_target_retarget.f
rtl/core/ctr_pkg.sv
rtl/core/ctr_cfg.sv
rtl/core/ctr_divider.sv
rtl/core/compact_target_retarget.sv
verif/compact_target_retarget_tb.sv
